>>> rtl/core/opg_pkg.sv
package opg_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TIMER_BITS = 14;
  localparam int CFG_DATA_BITS = (TIMER_BITS > SAMPLE_BITS) ? TIMER_BITS : SAMPLE_BITS;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ON = 2'd1;
  localparam logic [1:0] MODE_ALERT = 2'd2;
  localparam logic [1:0] MODE_OVERLOAD = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OC_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALERT_WINDOW = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OVERLOAD_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLEAN_WINDOW = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_BACKOFF = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BACKOFF = 3'd5;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  localparam logic [SAMPLE_BITS-1:0] OC_THRESHOLD_RST = SAMPLE_BITS'(4095);
  localparam logic [TIMER_BITS-1:0] ALERT_WINDOW_RST = TIMER_BITS'(20);
  localparam logic [TIMER_BITS-1:0] OVERLOAD_TIMEOUT_RST = TIMER_BITS'(100);
  localparam logic [TIMER_BITS-1:0] CLEAN_WINDOW_RST = TIMER_BITS'(5000);
  localparam logic [TIMER_BITS-1:0] MIN_BACKOFF_RST = TIMER_BITS'(40);
  localparam logic [TIMER_BITS-1:0] MAX_BACKOFF_RST = TIMER_BITS'(10000);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] oc_threshold;
    logic [TIMER_BITS-1:0]  alert_window;
    logic [TIMER_BITS-1:0]  overload_timeout;
    logic [TIMER_BITS-1:0]  clean_window;
    logic [TIMER_BITS-1:0]  min_backoff;
    logic [TIMER_BITS-1:0]  max_backoff;
  } cfg_t;

  typedef struct packed {
    logic                   req_type;
    logic                   power_request;
    logic                   fault_level;
    logic [SAMPLE_BITS-1:0] current_sample;
  } item_t;

  typedef struct packed {
    logic                   power_enable;
    logic [1:0]             mode;
    logic                   fault_seen;
    logic                   overcurrent_seen;
    logic [SAMPLE_BITS-1:0] held_sample;
    logic [TIMER_BITS-1:0]  backoff_now;
  } res_t;

endpackage

>>> rtl/core/opg_if.sv
interface opg_in_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic                           power_request;
  logic                           fault_level;
  logic [opg_pkg::SAMPLE_BITS-1:0] current_sample;

  modport source(output valid, output req_type, output power_request, output fault_level,
                 output current_sample, input ready);
  modport sink(input valid, input req_type, input power_request, input fault_level,
               input current_sample, output ready);
endinterface

interface opg_out_if;
  logic                           valid;
  logic                           ready;
  logic                           power_enable;
  logic [1:0]                     mode;
  logic                           fault_seen;
  logic                           overcurrent_seen;
  logic [opg_pkg::SAMPLE_BITS-1:0] held_sample;
  logic [opg_pkg::TIMER_BITS-1:0]  backoff_now;

  modport source(output valid, output power_enable, output mode, output fault_seen,
                 output overcurrent_seen, output held_sample, output backoff_now,
                 input ready);
  modport sink(input valid, input power_enable, input mode, input fault_seen,
               input overcurrent_seen, input held_sample, input backoff_now,
               output ready);
endinterface

>>> rtl/core/opg_cfg_regs.sv
module opg_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [opg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [opg_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output opg_pkg::cfg_t                     cfg
);
  import opg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      // out-of-range indexes fall through and change nothing
      case (cfg_index)
        CFG_OC_THRESHOLD:     cfg_nxt.oc_threshold = cfg_data[SAMPLE_BITS-1:0];
        CFG_ALERT_WINDOW:     cfg_nxt.alert_window = cfg_data[TIMER_BITS-1:0];
        CFG_OVERLOAD_TIMEOUT: cfg_nxt.overload_timeout = cfg_data[TIMER_BITS-1:0];
        CFG_CLEAN_WINDOW:     cfg_nxt.clean_window = cfg_data[TIMER_BITS-1:0];
        CFG_MIN_BACKOFF:      cfg_nxt.min_backoff = cfg_data[TIMER_BITS-1:0];
        CFG_MAX_BACKOFF:      cfg_nxt.max_backoff = cfg_data[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oc_threshold <= OC_THRESHOLD_RST;
      cfg_r.alert_window <= ALERT_WINDOW_RST;
      cfg_r.overload_timeout <= OVERLOAD_TIMEOUT_RST;
      cfg_r.clean_window <= CLEAN_WINDOW_RST;
      cfg_r.min_backoff <= MIN_BACKOFF_RST;
      cfg_r.max_backoff <= MAX_BACKOFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/opg_guard_core.sv
module opg_guard_core (
  input  logic          clk,
  input  logic          rst_n,
  input  opg_pkg::cfg_t cfg,
  opg_in_if.sink        in_ch,
  output logic          res_valid,
  input  logic          res_ready,
  output opg_pkg::res_t res
);
  import opg_pkg::*;

  logic                   s1_valid_r;
  item_t                  s1_item_r;
  logic                   s1_fire;

  logic [1:0]             mode_r, mode_nxt;
  logic [TIMER_BITS-1:0]  elapsed_r, elapsed_nxt;
  logic [TIMER_BITS-1:0]  backoff_r, backoff_nxt;
  logic [SAMPLE_BITS-1:0] hold_r, hold_nxt;

  logic [TIMER_BITS-1:0]  elapsed_inc;
  logic [TIMER_BITS:0]    backoff_dbl;
  logic                   fault;
  logic                   over;
  logic                   problem;
  logic [1:0]             target;

  assign s1_fire = s1_valid_r && res_ready;
  assign in_ch.ready = !s1_valid_r || res_ready;
  assign res_valid = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.req_type <= in_ch.req_type;
      s1_item_r.power_request <= in_ch.power_request;
      s1_item_r.fault_level <= in_ch.fault_level;
      s1_item_r.current_sample <= in_ch.current_sample;
    end
  end

  assign elapsed_inc = (elapsed_r == TIMER_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign backoff_dbl = {backoff_r, 1'b0};
  assign target = s1_item_r.power_request ? MODE_ON : MODE_OFF;

  always_comb begin
    mode_nxt = mode_r;
    elapsed_nxt = elapsed_r;
    backoff_nxt = backoff_r;
    hold_nxt = hold_r;
    fault = 1'b0;
    over = 1'b0;
    problem = 1'b0;
    if (s1_item_r.req_type == REQ_COMMAND) begin
      mode_nxt = target;
    end else begin
      fault = !s1_item_r.fault_level;
      over = s1_item_r.current_sample > cfg.oc_threshold;
      problem = fault || over;
      elapsed_nxt = elapsed_inc;
      case (mode_r)
        MODE_OFF: begin
          backoff_nxt = cfg.min_backoff;
        end
        MODE_ON: begin
          hold_nxt = s1_item_r.current_sample;
          if (problem) begin
            mode_nxt = MODE_ALERT;
          end else if (elapsed_inc > cfg.clean_window) begin
            backoff_nxt = cfg.min_backoff;
          end
        end
        MODE_ALERT: begin
          hold_nxt = s1_item_r.current_sample;
          if (problem) begin
            if (elapsed_inc >= cfg.overload_timeout) mode_nxt = MODE_OVERLOAD;
          end else if (elapsed_inc > cfg.alert_window) begin
            mode_nxt = MODE_ON;
          end
        end
        default: begin
          if (elapsed_inc >= backoff_r) begin
            // doubled wait, clamped to the ceiling
            if (backoff_dbl > {1'b0, cfg.max_backoff}) begin
              backoff_nxt = cfg.max_backoff;
            end else begin
              backoff_nxt = backoff_dbl[TIMER_BITS-1:0];
            end
            mode_nxt = MODE_ALERT;
          end
        end
      endcase
    end
    if (mode_nxt != mode_r) elapsed_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
      elapsed_r <= '0;
      backoff_r <= MIN_BACKOFF_RST;
      hold_r <= '0;
    end else if (s1_fire) begin
      mode_r <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      backoff_r <= backoff_nxt;
      hold_r <= hold_nxt;
    end
  end

  always_comb begin
    res.power_enable = (mode_nxt == MODE_ON) || (mode_nxt == MODE_ALERT);
    res.mode = mode_nxt;
    res.fault_seen = fault;
    res.overcurrent_seen = over;
    res.held_sample = hold_nxt;
    res.backoff_now = backoff_nxt;
  end

  a_mode_change_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && mode_nxt != mode_r) |=> elapsed_r == '0)
    else $error("elapsed time not cleared on mode change");

  a_state_holds_without_request: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(mode_r) && $stable(elapsed_r) && $stable(backoff_r))
    else $error("guard state moved without a request");

  a_off_tick_resets_backoff: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.req_type == REQ_TICK && mode_r == MODE_OFF)
      |=> backoff_r == $past(cfg.min_backoff))
    else $error("backoff not at minimum after a tick in off mode");

  a_command_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.req_type == REQ_COMMAND) |=> mode_r == $past(target))
    else $error("power command did not set the mode");

endmodule

>>> rtl/core/opg_out_reg.sv
module opg_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  output logic          res_ready,
  input  opg_pkg::res_t res,
  opg_out_if.source     out_ch
);
  import opg_pkg::*;

  logic out_valid_r;
  res_t out_data_r;

  // result register frees up in the same cycle it is taken
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_data_r <= res;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.power_enable = out_data_r.power_enable;
  assign out_ch.mode = out_data_r.mode;
  assign out_ch.fault_seen = out_data_r.fault_seen;
  assign out_ch.overcurrent_seen = out_data_r.overcurrent_seen;
  assign out_ch.held_sample = out_data_r.held_sample;
  assign out_ch.backoff_now = out_data_r.backoff_now;

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid_r)
    else $error("taken result did not reach the output register");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost or changed");

  a_no_take_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !res_ready)
    else $error("core result taken while output register is full");

endmodule

>>> rtl/core/overcurrent_power_guard.sv
// a taken request sits in the input register, is worked out in one combinational
// pass and lands in the result register once that register can take it
// throughput: one request per cycle while out_ch.ready is high; a stalled result
// holds both registers and drops in_ch.ready
// reset (synchronous, rst_n low): channels empty, mode off, elapsed 0,
// backoff 40, held sample 0, configuration at its default values
module overcurrent_power_guard (
  input  logic                              clk,
  input  logic                              rst_n,
  opg_in_if.sink                            in_ch,
  opg_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [opg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [opg_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import opg_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_ready;

  opg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  opg_guard_core u_guard_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  opg_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

>>> dv/overcurrent_power_guard_test.sv
module overcurrent_power_guard_test;
  timeunit 1ns;
  timeprecision 1ps;

  import opg_pkg::*;

  localparam int unsigned SAMPLE_TOP = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned TIMER_TOP = (1 << TIMER_BITS) - 1;
  localparam int unsigned LONG_HOLD = 150;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 145;
  // indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  opg_in_if in_ch ();
  opg_out_if out_ch ();

  overcurrent_power_guard dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // guard state as the block should hold it
  cfg_t guard_cfg;
  logic [1:0] g_mode = MODE_OFF;
  logic [TIMER_BITS-1:0] g_elapsed = '0;
  logic [TIMER_BITS-1:0] g_backoff = MIN_BACKOFF_RST;
  logic [SAMPLE_BITS-1:0] g_hold = '0;

  item_t request_backlog[$];
  res_t status_due[$];
  int unsigned queued_n = 0;
  int unsigned checked_n = 0;
  int unsigned mismatches = 0;
  int unsigned in_idle_pct = 20;
  int unsigned out_idle_pct = 20;
  int unsigned hold_asks = 0;
  bit in_taken = 1'b0;

  function automatic void switch_mode(logic [1:0] next);
    if (next != g_mode) begin
      g_mode = next;
      g_elapsed = '0;
    end
  endfunction

  function automatic res_t advance_guard(item_t req);
    res_t r;
    logic [TIMER_BITS:0] doubled;
    r = '0;
    if (req.req_type == REQ_COMMAND) begin
      switch_mode(req.power_request ? MODE_ON : MODE_OFF);
    end else begin
      r.fault_seen = !req.fault_level;
      r.overcurrent_seen = req.current_sample > guard_cfg.oc_threshold;
      if (g_elapsed != TIMER_MAX) g_elapsed = g_elapsed + 1'b1;
      case (g_mode)
        MODE_OFF: begin
          g_backoff = guard_cfg.min_backoff;
        end
        MODE_ON: begin
          g_hold = req.current_sample;
          if (!r.fault_seen && !r.overcurrent_seen) begin
            if (g_elapsed > guard_cfg.clean_window) g_backoff = guard_cfg.min_backoff;
          end else begin
            switch_mode(MODE_ALERT);
          end
        end
        MODE_ALERT: begin
          g_hold = req.current_sample;
          if (r.fault_seen || r.overcurrent_seen) begin
            if (g_elapsed >= guard_cfg.overload_timeout) switch_mode(MODE_OVERLOAD);
          end else if (g_elapsed > guard_cfg.alert_window) begin
            switch_mode(MODE_ON);
          end
        end
        default: begin
          if (g_elapsed >= g_backoff) begin
            doubled = {g_backoff, 1'b0};
            if (doubled > {1'b0, guard_cfg.max_backoff}) doubled = {1'b0, guard_cfg.max_backoff};
            g_backoff = doubled[TIMER_BITS-1:0];
            switch_mode(MODE_ALERT);
          end
        end
      endcase
    end
    r.mode = g_mode;
    r.power_enable = (g_mode == MODE_ON) || (g_mode == MODE_ALERT);
    r.held_sample = g_hold;
    r.backoff_now = g_backoff;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int unsigned pick_gap(int unsigned pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: one request per accepted handshake, gaps between them
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        nxt = request_backlog.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= nxt.req_type;
        in_ch.power_request <= nxt.power_request;
        in_ch.fault_level <= nxt.fault_level;
        in_ch.current_sample <= nxt.current_sample;
        send_gap = pick_gap(in_idle_pct);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver side ready, with an occasional long hold on request
  int unsigned ready_wait = 0;
  int unsigned holds_served = 0;
  always @(negedge clk) begin
    if (holds_served != hold_asks) begin
      holds_served = hold_asks;
      ready_wait = LONG_HOLD;
    end
    if (ready_wait > 0) begin
      ready_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      ready_wait = pick_gap(out_idle_pct);
      out_ch.ready <= (ready_wait == 0);
    end
  end

  always @(posedge clk) begin
    res_t want;
    item_t seen;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (status_due.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("power_enable", want.power_enable, out_ch.power_enable);
        check_field("mode", want.mode, out_ch.mode);
        check_field("fault_seen", want.fault_seen, out_ch.fault_seen);
        check_field("overcurrent_seen", want.overcurrent_seen, out_ch.overcurrent_seen);
        check_field("held_sample", want.held_sample, out_ch.held_sample);
        check_field("backoff_now", want.backoff_now, out_ch.backoff_now);
        checked_n++;
      end
    end
    if (in_taken) begin
      seen.req_type = in_ch.req_type;
      seen.power_request = in_ch.power_request;
      seen.fault_level = in_ch.fault_level;
      seen.current_sample = in_ch.current_sample;
      status_due.push_back(advance_guard(seen));
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("FAIL overcurrent_power_guard");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OC_THRESHOLD: guard_cfg.oc_threshold = val[SAMPLE_BITS-1:0];
      CFG_ALERT_WINDOW: guard_cfg.alert_window = val[TIMER_BITS-1:0];
      CFG_OVERLOAD_TIMEOUT: guard_cfg.overload_timeout = val[TIMER_BITS-1:0];
      CFG_CLEAN_WINDOW: guard_cfg.clean_window = val[TIMER_BITS-1:0];
      CFG_MIN_BACKOFF: guard_cfg.min_backoff = val[TIMER_BITS-1:0];
      CFG_MAX_BACKOFF: guard_cfg.max_backoff = val[TIMER_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(int unsigned limit, int unsigned alert, int unsigned timeout,
                            int unsigned clean, int unsigned min_b, int unsigned max_b);
    write_reg(CFG_OC_THRESHOLD, CFG_DATA_BITS'(limit));
    write_reg(CFG_ALERT_WINDOW, CFG_DATA_BITS'(alert));
    write_reg(CFG_OVERLOAD_TIMEOUT, CFG_DATA_BITS'(timeout));
    write_reg(CFG_CLEAN_WINDOW, CFG_DATA_BITS'(clean));
    write_reg(CFG_MIN_BACKOFF, CFG_DATA_BITS'(min_b));
    write_reg(CFG_MAX_BACKOFF, CFG_DATA_BITS'(max_b));
  endtask

  task automatic push_item(item_t req);
    request_backlog.push_back(req);
    queued_n++;
  endtask

  task automatic push_tick(logic fault_level, int unsigned sample);
    item_t req;
    req.req_type = REQ_TICK;
    req.power_request = 1'($urandom_range(0, 1));
    req.fault_level = fault_level;
    req.current_sample = SAMPLE_BITS'(sample);
    push_item(req);
  endtask

  task automatic push_command(logic turn_on);
    item_t req;
    req.req_type = REQ_COMMAND;
    req.power_request = turn_on;
    req.fault_level = 1'($urandom_range(0, 1));
    req.current_sample = SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP));
    push_item(req);
  endtask

  // runs of clean ticks and runs of trouble, with a few commands and noise mixed in
  task automatic queue_traffic(int unsigned count);
    int unsigned run_left;
    int unsigned roll;
    int unsigned lim;
    bit trouble;
    bit want_over;
    bit want_fault;
    item_t req;
    run_left = 0;
    trouble = 1'b0;
    lim = guard_cfg.oc_threshold;
    push_command(1'b1);
    repeat (count - 1) begin
      if (run_left == 0) begin
        trouble = ($urandom_range(0, 99) < 45);
        run_left = $urandom_range(1, 20);
      end
      run_left--;
      roll = $urandom_range(0, 99);
      req.req_type = REQ_TICK;
      req.power_request = 1'($urandom_range(0, 1));
      req.fault_level = 1'($urandom_range(0, 1));
      req.current_sample = SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP));
      if (roll < 4) begin
        req.req_type = REQ_COMMAND;
        req.power_request = ($urandom_range(0, 99) < 75);
      end else if (roll >= 8) begin
        roll = $urandom_range(0, 2);
        want_over = trouble && roll != 0 && lim < SAMPLE_TOP;
        want_fault = trouble && (roll != 1 || !want_over);
        req.fault_level = !want_fault;
        req.current_sample = SAMPLE_BITS'(want_over ? $urandom_range(lim + 1, SAMPLE_TOP)
                                                    : $urandom_range(0, lim));
      end
      push_item(req);
    end
  endtask

  task automatic drain();
    wait (checked_n == queued_n);
    repeat (3) @(negedge clk);
  endtask

  initial begin
    guard_cfg.oc_threshold = OC_THRESHOLD_RST;
    guard_cfg.alert_window = ALERT_WINDOW_RST;
    guard_cfg.overload_timeout = OVERLOAD_TIMEOUT_RST;
    guard_cfg.clean_window = CLEAN_WINDOW_RST;
    guard_cfg.min_backoff = MIN_BACKOFF_RST;
    guard_cfg.max_backoff = MAX_BACKOFF_RST;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.power_request = 1'b0;
    in_ch.fault_level = 1'b1;
    in_ch.current_sample = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default limits: off mode ignores the inputs, commands, fault entry
    push_tick(1'b0, SAMPLE_TOP);
    push_command(1'b0);
    push_command(1'b1);
    push_command(1'b1);
    push_tick(1'b1, SAMPLE_TOP);
    push_tick(1'b0, 'h555);
    push_command(1'b1);
    push_command(1'b0);
    drain();

    // tight timers: alert entry and return, command out of alert, backoff reset;
    // limit written with stray upper bits that must be dropped
    set_limits('h3064, 2, 3, 4, 1, 3);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, CFG_DATA_BITS'(5));
    push_tick(1'b1, 0);
    push_command(1'b1);
    push_tick(1'b1, 100);
    push_tick(1'b1, 101);
    push_tick(1'b0, SAMPLE_TOP);
    push_tick(1'b1, SAMPLE_TOP);
    push_tick(1'b1, 0);
    repeat (3) push_tick(1'b0, 0);
    repeat (2) push_tick(1'b1, 0);
    repeat (3) push_tick(1'b0, 0);
    push_command(1'b1);
    repeat (5) push_tick(1'b1, 0);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      in_idle_pct = $urandom_range(10, 40);
      out_idle_pct = $urandom_range(10, 40);
      case (p)
        0: set_limits(OC_THRESHOLD_RST, ALERT_WINDOW_RST, OVERLOAD_TIMEOUT_RST,
                      CLEAN_WINDOW_RST, MIN_BACKOFF_RST, MAX_BACKOFF_RST);
        // zero minimum backoff: overload retries at once and doubling stays zero
        1: set_limits(0, 0, 0, 0, 0, 1);
        2: set_limits(SAMPLE_TOP, TIMER_TOP, TIMER_TOP, TIMER_TOP, TIMER_TOP, TIMER_TOP);
        default: set_limits($urandom_range(0, SAMPLE_TOP), $urandom_range(0, 10),
                            $urandom_range(0, 12), $urandom_range(0, 30),
                            $urandom_range(0, 8), $urandom_range(1, 60));
      endcase
      if (p == 3) begin
        // sender keeps pushing while the receiver holds off
        in_idle_pct = 0;
        queue_traffic(PHASE_ITEMS);
        hold_asks++;
      end else if (p == 5) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
        queue_traffic(PHASE_ITEMS);
      end else if (p == 7) begin
        queue_traffic(PHASE_ITEMS / 2);
        drain();
        queue_traffic(PHASE_ITEMS / 2);
      end else begin
        queue_traffic(PHASE_ITEMS);
      end
      drain();
    end

    wait (checked_n == queued_n);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("PASS overcurrent_power_guard");
    end else begin
      $display("FAIL overcurrent_power_guard");
    end
    $finish;
  end

endmodule
